/* design/ctrs_pkg.sv */
// Shared types and codes for the cooperative task release scheduler.
`timescale 1ns / 1ps

package ctrs_pkg;

	localparam int NUM_SLOTS_DEF = 8;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_DELETE   = 2'd2;
	localparam logic [1:0] OP_DISPATCH = 2'd3;

	localparam logic [1:0] KIND_RUN   = 2'd0;
	localparam logic [1:0] KIND_ADDED = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  handle;
		logic [15:0] delay;
		logic [15:0] period;
		logic [2:0]  slot;
		logic        del_ok;
	} item_t;

	typedef struct packed {
		logic [7:0]  handle;
		logic [15:0] count;
		logic [15:0] period;
		logic [15:0] pending;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* design/cooperative_task_release_scheduler.sv */
// Top level of the cooperative task release scheduler.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: action, task_handle, first_delay, period, slot
// m_*       out  m_tvalid/m_tready  m_tuser: kind; m_tdata: slot_index, run_handle; m_tlast
//
// Add and delete are done in the executor's idle state. Tick and dispatch walk the slot table
// through the slot RAM read port, one slot per cycle unless the result channel stalls the walk.
// A two-entry queue lets new items be accepted while a walk is running.
// Reset empties the table by clearing the used marks; the RAM needs no clearing pass.
// A stalled result channel holds the walk at the slot that has a result to give.
`timescale 1ns / 1ps

module cooperative_task_release_scheduler #(
	parameter int NUM_SLOTS = ctrs_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // action[1:0], task_handle[9:2], first_delay[25:10],
	                              // period[41:26], slot[44:42], zero[47:45]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // slot_index[2:0], run_handle[10:3], zero[15:11]
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic             q_valid;
	logic             q_pop;
	ctrs_pkg::item_t  q_item;
	logic             ram_we;
	logic             ram_re;
	logic [SW-1:0]    ram_waddr;
	logic [SW-1:0]    ram_raddr;
	ctrs_pkg::entry_t ram_wdata;
	ctrs_pkg::entry_t ram_rdata;

	ctrs_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ctrs_ram #(
		.WIDTH(ctrs_pkg::ENTRY_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ctrs_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* design/ctrs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ctrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/ctrs_front.sv */
// Input side: decodes each item and keeps it in a two-entry queue for the walker.
`timescale 1ns / 1ps

module ctrs_front #(
	parameter int NUM_SLOTS = ctrs_pkg::NUM_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [47:0]         s_tdata,
	output logic                q_valid,
	output ctrs_pkg::item_t     q_item,
	input  logic                q_pop
);

	ctrs_pkg::item_t slot_q [2];
	ctrs_pkg::item_t dec;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	always_comb begin
		dec.op     = s_tdata[1:0];
		dec.handle = s_tdata[9:2];
		dec.delay  = s_tdata[25:10];
		dec.period = s_tdata[41:26];
		dec.slot   = s_tdata[44:42];
		dec.del_ok = (32'(s_tdata[44:42]) < NUM_SLOTS);
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

/* design/ctrs_back.sv */
// Execution side: slot table walker for tick and dispatch, add and delete, result register.
`timescale 1ns / 1ps

module ctrs_back #(
	parameter int NUM_SLOTS = ctrs_pkg::NUM_SLOTS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ctrs_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          ram_we,
	output logic [SW-1:0]                 ram_waddr,
	output ctrs_pkg::entry_t              ram_wdata,
	output logic                          ram_re,
	output logic [SW-1:0]                 ram_raddr,
	input  ctrs_pkg::entry_t              ram_rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]           state_q, state_d;
	logic [NUM_SLOTS-1:0] used_q, used_d;
	logic [SW-1:0]        idx_q, idx_d;
	logic                 tick_q, tick_d;
	logic                 hold_v_q, hold_v_d;
	logic [SW-1:0]        hold_idx_q, hold_idx_d;
	logic [7:0]           hold_h_q, hold_h_d;
	logic                 out_v_q;
	logic [1:0]           out_kind_q, out_kind_d;
	logic [2:0]           out_idx_q, out_idx_d;
	logic [7:0]           out_h_q, out_h_d;
	logic                 out_last_q, out_last_d;
	logic                 load_out;
	logic                 out_free;
	logic                 free_found;
	logic [SW-1:0]        free_idx;
	logic                 is_last_slot;
	logic                 cur_used;
	logic [15:0]          cnt_upd;
	logic [15:0]          pend_upd;
	logic                 emit;
	logic [SW-1:0]        del_idx;

	assign out_free     = !out_v_q || m_tready;
	assign is_last_slot = (idx_q == SW'(NUM_SLOTS - 1));
	assign cur_used     = used_q[idx_q];
	assign del_idx      = SW'(q_item.slot);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	always_comb begin
		cnt_upd  = ram_rdata.count;
		pend_upd = ram_rdata.pending;
		if (tick_q) begin
			if (ram_rdata.count == 16'd0) begin
				cnt_upd = ram_rdata.period - 16'd1;
				if (ram_rdata.pending != 16'hFFFF) begin
					pend_upd = ram_rdata.pending + 16'd1;
				end
			end else begin
				cnt_upd = ram_rdata.count - 16'd1;
			end
		end
		emit = cur_used && (pend_upd != 16'd0);
	end

	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		idx_d      = idx_q;
		tick_d     = tick_q;
		hold_v_d   = hold_v_q;
		hold_idx_d = hold_idx_q;
		hold_h_d   = hold_h_q;
		load_out   = 1'b0;
		out_kind_d = out_kind_q;
		out_idx_d  = out_idx_q;
		out_h_d    = out_h_q;
		out_last_d = out_last_q;
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = '{handle: ram_rdata.handle, count: cnt_upd, period: ram_rdata.period,
			pending: emit ? pend_upd - 16'd1 : pend_upd};
		ram_re     = 1'b0;
		ram_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						ctrs_pkg::OP_ADD: begin
							if (out_free) begin
								q_pop      = 1'b1;
								load_out   = 1'b1;
								out_last_d = 1'b1;
								if (free_found) begin
									used_d[free_idx] = 1'b1;
									ram_we     = 1'b1;
									ram_waddr  = free_idx;
									ram_wdata  = '{handle: q_item.handle, count: q_item.delay,
										period: q_item.period, pending: 16'd0};
									out_kind_d = ctrs_pkg::KIND_ADDED;
									out_idx_d  = 3'(free_idx);
									out_h_d    = q_item.handle;
								end else begin
									out_kind_d = ctrs_pkg::KIND_FULL;
									out_idx_d  = 3'd0;
									out_h_d    = 8'd0;
								end
							end
						end
						ctrs_pkg::OP_DELETE: begin
							q_pop = 1'b1;
							if (q_item.del_ok) begin
								used_d[del_idx] = 1'b0;
							end
						end
						default: begin
							q_pop     = 1'b1;
							tick_d    = (q_item.op == ctrs_pkg::OP_TICK);
							idx_d     = '0;
							hold_v_d  = 1'b0;
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = ST_WALK;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!(emit && hold_v_q && !out_free)) begin
					ram_we = cur_used;
					if (emit) begin
						if (hold_v_q) begin
							load_out   = 1'b1;
							out_kind_d = ctrs_pkg::KIND_RUN;
							out_idx_d  = 3'(hold_idx_q);
							out_h_d    = hold_h_q;
							out_last_d = 1'b0;
						end
						hold_v_d   = 1'b1;
						hold_idx_d = idx_q;
						hold_h_d   = ram_rdata.handle;
					end
					if (is_last_slot) begin
						state_d = ST_FLUSH;
					end else begin
						idx_d     = idx_q + SW'(1);
						ram_re    = 1'b1;
						ram_raddr = idx_q + SW'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out   = 1'b1;
					out_kind_d = ctrs_pkg::KIND_RUN;
					out_idx_d  = 3'(hold_idx_q);
					out_h_d    = hold_h_q;
					out_last_d = 1'b1;
					hold_v_d   = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			idx_q    <= '0;
			tick_q   <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			idx_q    <= idx_d;
			tick_q   <= tick_d;
			hold_v_q <= hold_v_d;
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_idx_q <= hold_idx_d;
		hold_h_q   <= hold_h_d;
		out_kind_q <= out_kind_d;
		out_idx_q  <= out_idx_d;
		out_h_q    <= out_h_d;
		out_last_q <= out_last_d;
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {5'd0, out_h_q, out_idx_q};
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_hold_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (state_q == ST_WALK || state_q == ST_FLUSH))
		else $error("held run result outside a table walk");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= SW'(NUM_SLOTS - 1))
		else $error("walk index beyond the table");
	a_write_used_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == ST_WALK) |-> used_q[idx_q])
		else $error("walk wrote back an unused slot");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register overwritten before it was taken");
	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !hold_v_q) |=> state_q == ST_IDLE)
		else $error("walk did not return to idle");
`endif

endmodule

/* tb/tb_cooperative_task_release_scheduler.sv */
// Self-checking testbench for the cooperative task release scheduler.
`timescale 1ns / 1ps

module tb_cooperative_task_release_scheduler;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4 * ctrs_pkg::NUM_SLOTS_DEF + 8;
	localparam int RANDOM_PER_PHASE = 160;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  task_handle;
		logic [15:0] first_delay;
		logic [15:0] period;
		logic [2:0]  slot;
	} sched_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot_index;
		logic [7:0] run_handle;
		logic       last;
	} sched_result_t;

	class sched_scoreboard;
		logic          used[ctrs_pkg::NUM_SLOTS_DEF];
		logic [7:0]    handle[ctrs_pkg::NUM_SLOTS_DEF];
		logic [15:0]   count[ctrs_pkg::NUM_SLOTS_DEF];
		logic [15:0]   reload[ctrs_pkg::NUM_SLOTS_DEF];
		logic [15:0]   pending[ctrs_pkg::NUM_SLOTS_DEF];
		sched_result_t due_results[$];
		int            errors;
		int            items_seen;
		int            results_seen;
		int            runs_seen;
		int            full_seen;

		function new();
			errors = 0;
			items_seen = 0;
			results_seen = 0;
			runs_seen = 0;
			full_seen = 0;
			for (int s = 0; s < ctrs_pkg::NUM_SLOTS_DEF; s++) begin
				clear_slot(s);
			end
		endfunction

		function void clear_slot(int s);
			used[s] = 1'b0;
			handle[s] = '0;
			count[s] = '0;
			reload[s] = '0;
			pending[s] = '0;
		endfunction

		function void release_due();
			int first;
			sched_result_t r;
			first = due_results.size();
			for (int s = 0; s < ctrs_pkg::NUM_SLOTS_DEF; s++) begin
				if (used[s] && pending[s] != 16'd0) begin
					r.kind = ctrs_pkg::KIND_RUN;
					r.slot_index = s[2:0];
					r.run_handle = handle[s];
					r.last = 1'b0;
					due_results.push_back(r);
					pending[s] = pending[s] - 16'd1;
				end
			end
			if (due_results.size() > first) begin
				due_results[due_results.size() - 1].last = 1'b1;
			end
		endfunction

		function void note_item(sched_item_t it);
			bit placed;
			sched_result_t r;
			items_seen++;
			case (it.action)
				ctrs_pkg::OP_TICK: begin
					for (int s = 0; s < ctrs_pkg::NUM_SLOTS_DEF; s++) begin
						if (used[s]) begin
							if (count[s] == 16'd0) begin
								if (pending[s] != 16'hFFFF) pending[s] = pending[s] + 16'd1;
								count[s] = reload[s] - 16'd1;
							end else begin
								count[s] = count[s] - 16'd1;
							end
						end
					end
					release_due();
				end
				ctrs_pkg::OP_DISPATCH: release_due();
				ctrs_pkg::OP_DELETE: begin
					if (int'(it.slot) < ctrs_pkg::NUM_SLOTS_DEF) clear_slot(int'(it.slot));
				end
				default: begin
					placed = 1'b0;
					r.kind = ctrs_pkg::KIND_FULL;
					r.slot_index = '0;
					r.run_handle = '0;
					r.last = 1'b1;
					for (int s = 0; s < ctrs_pkg::NUM_SLOTS_DEF; s++) begin
						if (!placed && !used[s]) begin
							placed = 1'b1;
							used[s] = 1'b1;
							handle[s] = it.task_handle;
							count[s] = it.first_delay;
							reload[s] = it.period;
							pending[s] = '0;
							r.kind = ctrs_pkg::KIND_ADDED;
							r.slot_index = s[2:0];
							r.run_handle = it.task_handle;
						end
					end
					due_results.push_back(r);
				end
			endcase
		endfunction

		function void check_item(sched_result_t got);
			sched_result_t want;
			results_seen++;
			if (got.kind == ctrs_pkg::KIND_RUN) runs_seen++;
			if (got.kind == ctrs_pkg::KIND_FULL) full_seen++;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d slot %0d handle %0d last %0d",
				         $time, got.kind, got.slot_index, got.run_handle, got.last);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind) begin
				errors++;
				$display("%0t: kind mismatch, expected %0d, actual %0d",
				         $time, want.kind, got.kind);
			end
			if (got.slot_index !== want.slot_index) begin
				errors++;
				$display("%0t: slot_index mismatch, expected %0d, actual %0d",
				         $time, want.slot_index, got.slot_index);
			end
			if (got.run_handle !== want.run_handle) begin
				errors++;
				$display("%0t: run_handle mismatch, expected %0d, actual %0d",
				         $time, want.run_handle, got.run_handle);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last mismatch, expected %0d, actual %0d",
				         $time, want.last, got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 65;
	int          hold_epoch = 0;
	int          cycles = 0;

	sched_scoreboard sb = new();

	cooperative_task_release_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results still due",
		         cycles, sb.due_results.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int hold_seen;
		int hold_left;
		sched_result_t got;
		hold_seen = 0;
		hold_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.slot_index = m_tdata[2:0];
				got.run_handle = m_tdata[10:3];
				got.last = m_tlast;
				sb.check_item(got);
			end
			if (hold_seen != hold_epoch) begin
				hold_seen = hold_epoch;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input sched_item_t it);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, it.slot, it.period, it.first_delay, it.task_handle, it.action};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic send_op(input logic [1:0] action, input logic [7:0] task_handle,
	                       input logic [15:0] first_delay, input logic [15:0] period,
	                       input logic [2:0] slot);
		sched_item_t it;
		it.action = action;
		it.task_handle = task_handle;
		it.first_delay = first_delay;
		it.period = period;
		it.slot = slot;
		send_item(it);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic sched_item_t random_item();
		sched_item_t it;
		int unsigned pick;
		it.task_handle = 8'($urandom_range(255));
		it.first_delay = 16'($urandom_range(65535));
		it.period = 16'($urandom_range(65535));
		it.slot = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 45) it.action = ctrs_pkg::OP_TICK;
		else if (pick < 66) it.action = ctrs_pkg::OP_ADD;
		else if (pick < 82) it.action = ctrs_pkg::OP_DELETE;
		else it.action = ctrs_pkg::OP_DISPATCH;
		if (it.action == ctrs_pkg::OP_ADD && $urandom_range(99) < 80) begin
			it.first_delay = 16'($urandom_range(6));
			it.period = 16'($urandom_range(8));
		end
		return it;
	endfunction

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes of the fields, full table, deletes, reuse.
		send_op(ctrs_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
		send_op(ctrs_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_op(ctrs_pkg::OP_ADD, 8'h00, 16'h0000, 16'h0001, 3'd0);
		send_op(ctrs_pkg::OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
		send_op(ctrs_pkg::OP_ADD, 8'hA5, 16'h0001, 16'h0000, 3'd2);
		send_op(ctrs_pkg::OP_ADD, 8'h5A, 16'h0000, 16'h0002, 3'd5);
		send_op(ctrs_pkg::OP_ADD, 8'h11, 16'h0001, 16'h0003, 3'd1);
		send_op(ctrs_pkg::OP_ADD, 8'h22, 16'h0002, 16'h0002, 3'd4);
		send_op(ctrs_pkg::OP_ADD, 8'h33, 16'h0000, 16'h0001, 3'd3);
		send_op(ctrs_pkg::OP_ADD, 8'h44, 16'h0001, 16'h0001, 3'd6);
		send_op(ctrs_pkg::OP_ADD, 8'h77, 16'h0003, 16'h0004, 3'd0);
		send_op(ctrs_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_op(ctrs_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_op(ctrs_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_op(ctrs_pkg::OP_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7);
		send_op(ctrs_pkg::OP_DELETE, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
		send_op(ctrs_pkg::OP_ADD, 8'h88, 16'h0000, 16'h0002, 3'd0);
		send_op(ctrs_pkg::OP_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_op(ctrs_pkg::OP_ADD, 8'h99, 16'h0000, 16'h0001, 3'd0);
		repeat (4) send_op(ctrs_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 21; recv_idle_pct = 65; end
				1: begin send_idle_pct = 65; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (phase == 0) hold_epoch++;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_item(random_item());
			end
			wait_drained();
		end

		$display("Covered %0d items and %0d results: %0d task runs, %0d full-table reports,",
		         sb.items_seen, sb.results_seen, sb.runs_seen, sb.full_seen);
		$display("under three idle patterns and one long output stall.");
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
